[design/rab_pkg.sv]
// ----------------------------------------------------------------------------
// rab_pkg
// shared types, constants and helpers of the running-average background
// subtractor
// ----------------------------------------------------------------------------
`default_nettype none

package rab_pkg;

    localparam int NCH      = 3;
    localparam int CHAN_W   = 8;
    localparam int FRAC     = 4;
    localparam int MEAN_W   = CHAN_W + FRAC;
    localparam int VAR_W    = 19;
    localparam int ROUND    = 1 << (FRAC - 1);
    localparam int ROOT_W   = (VAR_W + FRAC + 1) / 2;
    localparam int REM_W    = ROOT_W + 2;
    localparam int SQ_STEPS = 4;
    localparam int SQ_STAGES = (ROOT_W + SQ_STEPS - 1) / SQ_STEPS;
    localparam int CFG_W    = 19;
    localparam int CNT_W    = 19;
    localparam int FRM_W    = 8;
    localparam int MARGIN_W = 8;
    localparam int CMP_W    = MEAN_W + 3;
    localparam int FIFO_DEPTH = 4;

    localparam logic [VAR_W-1:0] VAR_MAX    = {VAR_W{1'b1}};
    localparam logic [FRM_W-1:0] FRAMES_MAX = {FRM_W{1'b1}};

    localparam int DEF_MAX_PIXELS = 262144;

    localparam logic [CNT_W-1:0]    RST_PIXEL_COUNT     = CNT_W'(230400);
    localparam logic [FRM_W-1:0]    RST_TRAINING_FRAMES = FRM_W'(50);
    localparam logic [MARGIN_W-1:0] RST_HIGH_MARGIN     = MARGIN_W'(40);
    localparam logic [MARGIN_W-1:0] RST_LOW_MARGIN      = MARGIN_W'(40);

    typedef enum logic [1:0] {
        REG_PIXEL_COUNT     = 2'd0,
        REG_TRAINING_FRAMES = 2'd1,
        REG_HIGH_MARGIN     = 2'd2,
        REG_LOW_MARGIN      = 2'd3
    } rab_reg_t;

    typedef struct packed {
        logic first;
        logic training;
        logic last;
    } rab_flags_t;

    localparam int FLAGS_W = $bits(rab_flags_t);

    typedef logic [NCH-1:0][CHAN_W-1:0] rab_pix_t;

    typedef struct packed {
        logic [MEAN_W-1:0] mean;
        logic [VAR_W-1:0]  variance;
    } rab_entry_t;

    typedef rab_entry_t [NCH-1:0] rab_word_t;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } rab_sqrt_t;

    // one digit of the restoring square root
    function automatic rab_sqrt_t sqrt_step(rab_sqrt_t st, logic [1:0] pair);
        logic [REM_W-1:0] r;
        logic [REM_W-1:0] t;
        rab_sqrt_t        o;
        r = {st.rem[REM_W-3:0], pair};
        t = {st.root, 2'b01};
        if (r >= t)
        begin
            o.rem  = r - t;
            o.root = {st.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            o.rem  = r;
            o.root = {st.root[ROOT_W-2:0], 1'b0};
        end
        return o;
    endfunction

endpackage

`default_nettype wire

[design/running_average_background_subtractor_top.sv]
// ----------------------------------------------------------------------------
// running_average_background_subtractor_top
// per-pixel running mean / variance background model with foreground test
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+-------------------------------
//   in       | in        | in_valid/in_stall  | chan0, chan1, chan2
//   out      | out       | out_valid/out_stall| foreground, in_training, frame_end
//   cfg      | in        | cfg_we             | cfg_index, cfg_data
//
// one pixel per clock sustained unless an output stall holds the pipeline; from
// accept to result a pixel passes the memory read, the update stage and the three root stages
// the model memory is not cleared at reset; the first frame writes every entry
// an output stall freezes the back pipeline; the four-word queue keeps the
// input open until it fills
// ----------------------------------------------------------------------------
`default_nettype none

module running_average_background_subtractor_top
    import rab_pkg::*;
#(
    parameter int MAX_PIXELS = DEF_MAX_PIXELS
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [CHAN_W-1:0] chan0,
    input  wire logic [CHAN_W-1:0] chan1,
    input  wire logic [CHAN_W-1:0] chan2,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   foreground,
    output logic                   in_training,
    output logic                   frame_end,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data
);

    localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int DW = AW + FLAGS_W + NCH * CHAN_W;

    logic [CNT_W-1:0]    pixel_count_reg;
    logic [FRM_W-1:0]    training_frames_reg;
    logic [MARGIN_W-1:0] high_margin_reg;
    logic [MARGIN_W-1:0] low_margin_reg;

    rab_pix_t   pix;
    logic       push;
    logic [AW-1:0] push_addr;
    rab_flags_t push_flags;
    logic       q_full;
    logic       q_nonempty;
    logic       q_pop;
    logic [DW-1:0] q_rdata;
    logic [AW-1:0] q_addr;
    rab_flags_t q_flags;
    rab_pix_t   q_pix;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_count_reg     <= RST_PIXEL_COUNT;
            training_frames_reg <= RST_TRAINING_FRAMES;
            high_margin_reg     <= RST_HIGH_MARGIN;
            low_margin_reg      <= RST_LOW_MARGIN;
        end
        else if (cfg_we)
        begin
            case (rab_reg_t'(cfg_index))
                REG_PIXEL_COUNT:     pixel_count_reg     <= cfg_data[CNT_W-1:0];
                REG_TRAINING_FRAMES: training_frames_reg <= cfg_data[FRM_W-1:0];
                REG_HIGH_MARGIN:     high_margin_reg     <= cfg_data[MARGIN_W-1:0];
                REG_LOW_MARGIN:      low_margin_reg      <= cfg_data[MARGIN_W-1:0];
                default:             ;
            endcase
        end
    end

    assign pix[0] = chan0;
    assign pix[1] = chan1;
    assign pix[2] = chan2;

    rab_front #(
        .MAX_PIXELS (MAX_PIXELS),
        .AW         (AW)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .pixel_count     (pixel_count_reg),
        .training_frames (training_frames_reg),
        .q_full          (q_full),
        .push            (push),
        .push_addr       (push_addr),
        .push_flags      (push_flags)
    );

    rab_fifo #(
        .DW    (DW),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wdata    ({push_addr, push_flags, pix}),
        .pop      (q_pop),
        .full     (q_full),
        .nonempty (q_nonempty),
        .rdata    (q_rdata)
    );

    assign {q_addr, q_flags, q_pix} = q_rdata;

    rab_back #(
        .MAX_PIXELS (MAX_PIXELS),
        .AW         (AW)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_nonempty  (q_nonempty),
        .q_pop       (q_pop),
        .q_addr      (q_addr),
        .q_flags     (q_flags),
        .q_pix       (q_pix),
        .high_margin (high_margin_reg),
        .low_margin  (low_margin_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .foreground  (foreground),
        .in_training (in_training),
        .frame_end   (frame_end)
    );

endmodule

`default_nettype wire

[design/rab_fifo.sv]
// ----------------------------------------------------------------------------
// rab_fifo
// short word queue between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none

module rab_fifo
    import rab_pkg::*;
#(
    parameter int DW    = 8,
    parameter int DEPTH = FIFO_DEPTH
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire logic [DW-1:0] wdata,
    input  wire logic          pop,
    output logic               full,
    output logic               nonempty,
    output logic [DW-1:0]      rdata
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DW-1:0] mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push;
    logic          do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign nonempty = (count_reg != '0);
    assign rdata    = mem[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && nonempty;

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("queue written while full");
`endif

endmodule

`default_nettype wire

[design/rab_front.sv]
// ----------------------------------------------------------------------------
// rab_front
// takes pixels, tracks position and frame count, tags each word for the back
// ----------------------------------------------------------------------------
`default_nettype none

module rab_front
    import rab_pkg::*;
#(
    parameter int MAX_PIXELS = DEF_MAX_PIXELS,
    parameter int AW         = 18
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic [CNT_W-1:0] pixel_count,
    input  wire logic [FRM_W-1:0] training_frames,
    input  wire logic             q_full,
    output logic                  push,
    output logic [AW-1:0]         push_addr,
    output rab_flags_t            push_flags
);

    localparam int CW = (AW + 1 > CNT_W) ? AW + 1 : CNT_W;

    logic [AW-1:0]    pos_reg;
    logic [FRM_W-1:0] frames_reg;
    logic [CW-1:0]    cnt_ext;
    logic [CW-1:0]    cnt_eff;
    logic [CW-1:0]    pos_inc;
    logic             last;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        cnt_ext = CW'(pixel_count);
        if (cnt_ext == '0)
            cnt_eff = CW'(1);
        else if (cnt_ext > CW'(MAX_PIXELS))
            cnt_eff = CW'(MAX_PIXELS);
        else
            cnt_eff = cnt_ext;
        pos_inc = CW'(pos_reg) + CW'(1);
        last    = (pos_inc >= cnt_eff);
    end

    assign push_addr           = pos_reg;
    assign push_flags.first    = (frames_reg == '0);
    assign push_flags.training = (frames_reg == '0) || (frames_reg < training_frames);
    assign push_flags.last     = last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            frames_reg <= '0;
        end
        else if (push)
        begin
            if (last)
            begin
                pos_reg <= '0;
                if (frames_reg != FRAMES_MAX)
                    frames_reg <= frames_reg + 1'b1;
            end
            else
            begin
                pos_reg <= pos_inc[AW-1:0];
            end
        end
    end

endmodule

`default_nettype wire

[design/rab_back.sv]
// ----------------------------------------------------------------------------
// rab_back
// model memory, training update with forwarding, pipelined square root,
// range test and output register
// ----------------------------------------------------------------------------
`default_nettype none

module rab_back
    import rab_pkg::*;
#(
    parameter int MAX_PIXELS = DEF_MAX_PIXELS,
    parameter int AW         = 18
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                q_nonempty,
    output logic                     q_pop,
    input  wire logic [AW-1:0]       q_addr,
    input  wire rab_flags_t          q_flags,
    input  wire rab_pix_t            q_pix,
    input  wire logic [MARGIN_W-1:0] high_margin,
    input  wire logic [MARGIN_W-1:0] low_margin,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic                     foreground,
    output logic                     in_training,
    output logic                     frame_end
);

    localparam int SQ_W = 2 * MEAN_W;
    localparam int XW   = 2 * ROOT_W;

    rab_word_t mem [MAX_PIXELS];

    logic en;

    // read / forwarding stage
    logic       p1_valid_reg;
    logic [AW-1:0] p1_addr_reg;
    rab_flags_t p1_flags_reg;
    rab_pix_t   p1_pix_reg;
    rab_word_t  rdata_reg;
    rab_word_t  cur;

    // last write, still invisible to a read issued on the same edge
    logic       lw_valid_reg;
    logic [AW-1:0] lw_addr_reg;
    rab_word_t  lw_data_reg;

    // update stage
    logic       p2_valid_reg;
    logic [AW-1:0] p2_addr_reg;
    rab_flags_t p2_flags_reg;
    rab_pix_t   p2_pix_reg;
    rab_word_t  p2_old_reg;
    logic [NCH-1:0][MEAN_W-1:0]   p2_m2_reg;
    logic [NCH-1:0][MEAN_W:0]     p2_d_reg;
    logic [NCH-1:0][MEAN_W-1:0]   m2_next;
    logic [NCH-1:0][MEAN_W:0]     d_next;
    rab_word_t  wr_data;
    logic       wr_en;

    // square root stages
    logic       sq_valid_reg [SQ_STAGES];
    rab_flags_t sq_flags_reg [SQ_STAGES];
    rab_pix_t   sq_pix_reg   [SQ_STAGES];
    logic [NCH-1:0][MEAN_W-1:0] sq_mean_reg [SQ_STAGES];
    logic [NCH-1:0][XW-1:0]     sq_x_reg    [SQ_STAGES];
    rab_sqrt_t [NCH-1:0]        sq_st_reg   [SQ_STAGES];
    rab_sqrt_t [NCH-1:0]        sq_st_next  [SQ_STAGES];
    logic [NCH-1:0][XW-1:0]     x_next;

    // output register
    logic out_valid_reg;
    logic fg_reg;
    logic train_reg;
    logic last_reg;
    logic fg_next;

    assign en    = !out_valid_reg || !out_stall;
    assign q_pop = en && q_nonempty;
    assign wr_en = en && p2_valid_reg && p2_flags_reg.training;

    always_ff @(posedge clk)
    begin
        if (en)
            rdata_reg <= mem[q_addr];
        if (wr_en)
            mem[p2_addr_reg] <= wr_data;
    end

    always_comb
    begin
        logic [MEAN_W-1:0] s;
        logic [MEAN_W-1:0] m;
        logic [MEAN_W:0]   sum;
        if (p2_valid_reg && p2_flags_reg.training && (p2_addr_reg == p1_addr_reg))
            cur = wr_data;
        else if (lw_valid_reg && (lw_addr_reg == p1_addr_reg))
            cur = lw_data_reg;
        else
            cur = rdata_reg;
        for (int c = 0; c < NCH; c++)
        begin
            s   = MEAN_W'({p1_pix_reg[c], {FRAC{1'b0}}});
            m   = cur[c].mean;
            sum = {1'b0, m} + {1'b0, s} + (MEAN_W + 1)'(1);
            m2_next[c] = sum[MEAN_W:1];
            d_next[c]  = {1'b0, s} - {1'b0, sum[MEAN_W:1]};
        end
    end

    always_comb
    begin
        logic signed [SQ_W+1:0] sq;
        logic [SQ_W:0]          qv;
        logic [SQ_W+1:0]        vsum;
        logic [SQ_W+1:0]        vhalf;
        logic [MEAN_W-1:0]      s;
        for (int c = 0; c < NCH; c++)
        begin
            s     = MEAN_W'({p2_pix_reg[c], {FRAC{1'b0}}});
            sq    = $signed(p2_d_reg[c]) * $signed(p2_d_reg[c]);
            qv    = ({1'b0, sq[SQ_W-1:0]} + (SQ_W + 1)'(ROUND)) >> FRAC;
            vsum  = (SQ_W + 2)'(p2_old_reg[c].variance) + (SQ_W + 2)'(qv)
                    + (SQ_W + 2)'(1);
            vhalf = vsum >> 1;
            if (p2_flags_reg.first)
            begin
                wr_data[c].mean     = s;
                wr_data[c].variance = '0;
            end
            else
            begin
                wr_data[c].mean     = p2_m2_reg[c];
                wr_data[c].variance = (vhalf > (SQ_W + 2)'(VAR_MAX)) ? VAR_MAX
                                      : vhalf[VAR_W-1:0];
            end
            x_next[c] = XW'({p2_old_reg[c].variance, {FRAC{1'b0}}});
        end
    end

    // four root digits per stage
    always_comb
    begin
        rab_sqrt_t st;
        for (int k = 0; k < SQ_STAGES; k++)
        begin
            for (int c = 0; c < NCH; c++)
            begin
                st = (k == 0) ? rab_sqrt_t'(0) : sq_st_reg[(k == 0) ? 0 : k - 1][c];
                for (int i = 0; i < SQ_STEPS; i++)
                begin
                    if (k * SQ_STEPS + i < ROOT_W)
                    begin
                        if (k == 0)
                            st = sqrt_step(st,
                                x_next[c][XW - 1 - 2 * (k * SQ_STEPS + i) -: 2]);
                        else
                            st = sqrt_step(st,
                                sq_x_reg[(k == 0) ? 0 : k - 1][c]
                                    [XW - 1 - 2 * (k * SQ_STEPS + i) -: 2]);
                    end
                end
                sq_st_next[k][c] = st;
            end
        end
    end

    always_comb
    begin
        logic signed [CMP_W-1:0] s;
        logic signed [CMP_W-1:0] lower;
        logic signed [CMP_W-1:0] upper;
        logic signed [CMP_W-1:0] m;
        logic signed [CMP_W-1:0] dev;
        fg_next = 1'b0;
        for (int c = 0; c < NCH; c++)
        begin
            s     = CMP_W'({sq_pix_reg[SQ_STAGES-1][c], {FRAC{1'b0}}});
            m     = CMP_W'(sq_mean_reg[SQ_STAGES-1][c]);
            dev   = CMP_W'(sq_st_reg[SQ_STAGES-1][c].root);
            lower = m - dev - CMP_W'({low_margin, {FRAC{1'b0}}});
            upper = m + dev + CMP_W'({high_margin, {FRAC{1'b0}}});
            if ((s < lower) || (s > upper))
                fg_next = 1'b1;
        end
        if (sq_flags_reg[SQ_STAGES-1].training)
            fg_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_addr_reg  <= q_addr;
            p1_flags_reg <= q_flags;
            p1_pix_reg   <= q_pix;
            lw_addr_reg  <= p2_addr_reg;
            lw_data_reg  <= wr_data;
            p2_addr_reg  <= p1_addr_reg;
            p2_flags_reg <= p1_flags_reg;
            p2_pix_reg   <= p1_pix_reg;
            p2_old_reg   <= cur;
            p2_m2_reg    <= m2_next;
            p2_d_reg     <= d_next;
            for (int k = 0; k < SQ_STAGES; k++)
            begin
                sq_st_reg[k] <= sq_st_next[k];
                if (k == 0)
                begin
                    sq_flags_reg[k] <= p2_flags_reg;
                    sq_pix_reg[k]   <= p2_pix_reg;
                    for (int c = 0; c < NCH; c++)
                        sq_mean_reg[k][c] <= p2_old_reg[c].mean;
                    sq_x_reg[k] <= x_next;
                end
                else
                begin
                    sq_flags_reg[k] <= sq_flags_reg[k-1];
                    sq_pix_reg[k]   <= sq_pix_reg[k-1];
                    sq_mean_reg[k]  <= sq_mean_reg[k-1];
                    sq_x_reg[k]     <= sq_x_reg[k-1];
                end
            end
            fg_reg    <= fg_next;
            train_reg <= sq_flags_reg[SQ_STAGES-1].training;
            last_reg  <= sq_flags_reg[SQ_STAGES-1].last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            lw_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < SQ_STAGES; k++)
                sq_valid_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            p1_valid_reg <= q_pop;
            p2_valid_reg <= p1_valid_reg;
            lw_valid_reg <= wr_en;
            for (int k = 0; k < SQ_STAGES; k++)
                sq_valid_reg[k] <= (k == 0) ? p2_valid_reg
                                            : sq_valid_reg[(k == 0) ? 0 : k - 1];
            out_valid_reg <= sq_valid_reg[SQ_STAGES-1];
        end
    end

    assign out_valid   = out_valid_reg;
    assign foreground  = fg_reg;
    assign in_training = train_reg;
    assign frame_end   = last_reg;

`ifndef SYNTHESIS
    a_write_only_training: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> p2_valid_reg && p2_flags_reg.training)
        else $error("model written by a detection word");
    a_frozen_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> $stable(p1_valid_reg) && $stable(p2_valid_reg))
        else $error("pipeline moved while output stalled");
    a_no_fg_in_training: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(fg_reg && train_reg))
        else $error("foreground flagged during training");
    a_no_pop_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !q_pop)
        else $error("queue popped while output stalled");
`endif

endmodule

`default_nettype wire
